### src/hfc_pkg.sv
// Package for the headway following control step unit.
// Holds the word types, register map, reset values and datapath widths.
// No dependencies; every other file imports it.
package hfc_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Accumulator for the Q.28 control sum.
    localparam int ACC_W = 52;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAP_GAIN       = 3'd0,
        CFG_VELOCITY_GAIN  = 3'd1,
        CFG_HEADWAY        = 3'd2,
        CFG_STANDSTILL     = 3'd3,
        CFG_GAP_ERR_CAP    = 3'd4,
        CFG_ACCEL_STEP     = 3'd5,
        CFG_BRAKE_STEP     = 3'd6
    } cfg_index_t;

    localparam logic [15:0] RST_GAP_GAIN      = 16'd819;
    localparam logic [15:0] RST_VELOCITY_GAIN = 16'd2048;
    localparam logic [15:0] RST_HEADWAY       = 16'd4096;
    localparam logic [15:0] RST_STANDSTILL    = 16'd256;
    localparam logic [23:0] RST_GAP_ERR_CAP   = 24'd768;
    localparam logic [15:0] RST_ACCEL_STEP    = 16'd655;
    localparam logic [15:0] RST_BRAKE_STEP    = 16'd4915;

    typedef struct packed {
        logic [15:0] gap_gain;
        logic [15:0] velocity_gain;
        logic [15:0] headway;
        logic [15:0] standstill_distance;
        logic [23:0] gap_err_cap;
        logic [15:0] accel_step_limit;
        logic [15:0] brake_step_limit;
    } hfc_cfg_t;

    typedef struct packed {
        logic        mode;
        logic [23:0] gap;
        logic [15:0] own_speed;
        logic [15:0] lead_speed;
    } hfc_in_t;

    typedef struct packed {
        logic signed [15:0] accel_command;
        logic [15:0]        filtered_lead_speed;
    } hfc_out_t;

endpackage

### src/hfc_cfg_regs.sv
// Configuration register file for the headway following control step unit.
// Depends on hfc_pkg for the register map, reset values and hfc_cfg_t.
module hfc_cfg_regs
    import hfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output hfc_cfg_t               cfg
);

    hfc_cfg_t cfg_reg;
    hfc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAP_GAIN:      cfg_next.gap_gain            = cfg_data[15:0];
                CFG_VELOCITY_GAIN: cfg_next.velocity_gain       = cfg_data[15:0];
                CFG_HEADWAY:       cfg_next.headway             = cfg_data[15:0];
                CFG_STANDSTILL:    cfg_next.standstill_distance = cfg_data[15:0];
                CFG_GAP_ERR_CAP:   cfg_next.gap_err_cap         = cfg_data[23:0];
                CFG_ACCEL_STEP:    cfg_next.accel_step_limit    = cfg_data[15:0];
                CFG_BRAKE_STEP:    cfg_next.brake_step_limit    = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_gain            <= RST_GAP_GAIN;
            cfg_reg.velocity_gain       <= RST_VELOCITY_GAIN;
            cfg_reg.headway             <= RST_HEADWAY;
            cfg_reg.standstill_distance <= RST_STANDSTILL;
            cfg_reg.gap_err_cap         <= RST_GAP_ERR_CAP;
            cfg_reg.accel_step_limit    <= RST_ACCEL_STEP;
            cfg_reg.brake_step_limit    <= RST_BRAKE_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/hfc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hfc_pkg for the operand and product widths.
module hfc_mul
    import hfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [MUL_P_W-1:0] product
);

    logic signed [MUL_P_W-1:0] product_reg;
    logic signed [MUL_P_W-1:0] product_next;

    always_comb
    begin
        product_next = product_reg;
        if (en)
        begin
            product_next = MUL_P_W'(op_a) * MUL_P_W'(op_b);
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

### src/headway_following_control_step_unit.sv
// Top level of the headway following control step unit: sequencer and datapath.
// Depends on hfc_pkg, hfc_cfg_regs and hfc_mul.
//
//   channel  | signals                      | moves
//   ---------+------------------------------+-----------------------------
//   in       | in_valid, in_ready, in_data  | one control tick word
//   out      | out_valid, out_ready, out_data | one command word per tick
//   cfg      | cfg_we, cfg_index, cfg_data  | one register write, no wait
//
// A control tick runs S_FILT, S_GAP, S_VEL, S_SUM and S_SAT before the next
// acceptance, with three passes through the one shared multiplier; a filter
// reset word goes from S_FILT straight to S_SAT. The result word is written
// in S_SAT and held in an output register, so a new word is taken while it waits.
// rst_n clears the sequencer, filter state and out_valid; config regs take defaults.
// A stalled output only holds the final step until the register frees.
module headway_following_control_step_unit
    import hfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hfc_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hfc_out_t               out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FILT = 6'b000010,
        S_GAP  = 6'b000100,
        S_VEL  = 6'b001000,
        S_SUM  = 6'b010000,
        S_SAT  = 6'b100000
    } state_t;

    hfc_cfg_t cfg;

    state_t                    state_reg, state_next;
    hfc_in_t                   item_reg, item_next;
    logic [23:0]               fv_reg, fv_next;
    logic signed [25:0]        gap_err_reg, gap_err_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    hfc_out_t                  out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    // Combinational terms of the individual steps.
    logic [23:0]               sample;
    logic [24:0]               fv_up_bound;
    logic [24:0]               sample_down;
    logic [20:0]               ref_gap;
    logic signed [25:0]        gap_err_raw;
    logic signed [25:0]        gap_cap;
    logic signed [25:0]        vel_err;
    logic signed [31:0]        cmd_wide;
    logic signed [15:0]        cmd_sat;
    logic                      accept_in;
    logic                      out_free;

    hfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hfc_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    assign accept_in = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    assign sample      = {item_reg.lead_speed, 8'd0};
    assign fv_up_bound = {1'b0, fv_reg} + {9'd0, cfg.accel_step_limit};
    assign sample_down = {1'b0, sample} + {9'd0, cfg.brake_step_limit};

    // The multiplier holds the headway times the own speed while in S_GAP.
    assign ref_gap     = {1'b0, mul_p[31:12]} + {5'd0, cfg.standstill_distance};
    assign gap_err_raw = $signed({2'd0, item_reg.gap}) - $signed({5'd0, ref_gap});
    assign gap_cap     = $signed({2'd0, cfg.gap_err_cap});
    assign vel_err     = $signed({2'd0, fv_reg})
                         - $signed({2'd0, item_reg.own_speed, 8'd0});

    assign cmd_wide = acc_reg[ACC_W-1:20];

    always_comb
    begin
        if (cmd_wide > 32'sd32767)
        begin
            cmd_sat = 16'sh7FFF;
        end
        else if (cmd_wide < -32'sd32768)
        begin
            cmd_sat = -16'sh8000;
        end
        else
        begin
            cmd_sat = cmd_wide[15:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        fv_next        = fv_reg;
        gap_err_next   = gap_err_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    item_next  = in_data;
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                if (item_reg.mode)
                begin
                    fv_next    = {item_reg.own_speed, 8'd0};
                    acc_next   = '0;
                    state_next = S_SAT;
                end
                else
                begin
                    // Slew-rate limit toward the new leader sample.
                    if ({1'b0, sample} > fv_up_bound)
                    begin
                        fv_next = fv_up_bound[23:0];
                    end
                    else if (sample_down < {1'b0, fv_reg})
                    begin
                        fv_next = fv_reg - {8'd0, cfg.brake_step_limit};
                    end
                    else
                    begin
                        fv_next = sample;
                    end
                    mul_en     = 1'b1;
                    mul_a      = $signed({1'b0, cfg.headway});
                    mul_b      = $signed({10'd0, item_reg.own_speed});
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                gap_err_next = (gap_err_raw > gap_cap) ? gap_cap : gap_err_raw;
                mul_en       = 1'b1;
                mul_a        = $signed({1'b0, cfg.velocity_gain});
                mul_b        = vel_err;
                state_next   = S_VEL;
            end
            S_VEL:
            begin
                acc_next   = ACC_W'(mul_p);
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, cfg.gap_gain});
                mul_b      = gap_err_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // The gap term carries an extra factor of 256 to line up with Q.28.
                acc_next   = acc_reg + ACC_W'($signed({mul_p, 8'd0}));
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (out_free)
                begin
                    out_next.accel_command       = cmd_sat;
                    out_next.filtered_lead_speed = fv_reg[23:8];
                    out_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fv_reg        <= fv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        gap_err_reg <= gap_err_next;
        acc_reg     <= acc_next;
        out_reg     <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### src/hfc_checker.sv
// Port-level checker for the headway following control step unit, with its bind.
// Depends on hfc_pkg for the word types.
module hfc_checker
    import hfc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input hfc_out_t out_data
);

    // A waiting result word holds until it is taken.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result word changed or dropped while stalled");

    // Once reset has been seen at a clock edge, no result word is pending.
    property p_reset_empty;
        @(posedge clk) !rst_n |=> !out_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result word valid during reset");

    // An accepted word keeps in_ready low while the unit works through its step.
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input taken again before the step finished");

    // A new result word appears only as the unit returns to idle.
    property p_result_at_idle;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready;
    endproperty
    a_result_at_idle: assert property (p_result_at_idle)
        else $error("result word raised while the unit is still busy");

endmodule

bind headway_following_control_step_unit hfc_checker u_hfc_checker (.*);
